// ===== hdl/nrpe_pkg.sv =====
`default_nettype none

package nrpe_pkg;

	// Default build values for the top-level parameters.
	localparam int NRPE_FIELD_CHARS = 10;
	localparam int NRPE_FRACTION_DIGITS = 4;

	// Widths of the result values and of the power-of-ten table.
	localparam int VALUE_W = 30;
	localparam int POW10_W = 20;

	// Accumulators saturate at nine decimal nines.
	localparam logic [VALUE_W-1:0] SAT_MAX = 30'd999999999;

	// Length of the sentence header.
	localparam logic [2:0] HDR_LEN = 3'd6;

	// ASCII codes that the parser looks for.
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_A      = 8'h41;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_0      = 8'h30;
	localparam logic [7:0] CH_9      = 8'h39;

	// Sentence parse phases.
	typedef enum logic [2:0] {
		PH_SEARCH   = 3'd0,
		PH_WAIT_A   = 3'd1,
		PH_SKIP_LAT = 3'd2,
		PH_LAT      = 3'd3,
		PH_SKIP_LON = 3'd4,
		PH_LON      = 3'd5,
		PH_WAIT_LF  = 3'd6
	} phase_t;

	// Result of one parse step.
	typedef struct packed {
		logic               emit;
		logic [VALUE_W-1:0] lat;
		logic [VALUE_W-1:0] lon;
	} result_t;

	// Characters of the "$GPRMC" header by position.
	function automatic logic [7:0] hdr_char(input logic [2:0] idx);
		logic [7:0] ch;
		unique case (idx)
			3'd0: ch = CH_DOLLAR;
			3'd1: ch = 8'h47;
			3'd2: ch = 8'h50;
			3'd3: ch = 8'h52;
			3'd4: ch = 8'h4D;
			3'd5: ch = 8'h43;
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

	// Powers of ten used to pad a short fraction.
	function automatic logic [POW10_W-1:0] pow10(input logic [2:0] k);
		logic [POW10_W-1:0] p;
		unique case (k)
			3'd0: p = 20'd1;
			3'd1: p = 20'd10;
			3'd2: p = 20'd100;
			3'd3: p = 20'd1000;
			3'd4: p = 20'd10000;
			3'd5: p = 20'd100000;
			3'd6: p = 20'd1000000;
			default: p = 20'd0;
		endcase
		return p;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/nrpe_hdr_match.sv =====
`default_nettype none

module nrpe_hdr_match
	import nrpe_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       step,
	input  wire logic [7:0] rx_byte,
	output logic            hit
);

	logic [2:0] count_q;
	logic [2:0] count_n;

	// Advance on the expected character, restart on a dollar sign.
	always_comb begin
		if (count_q < HDR_LEN && rx_byte == hdr_char(count_q)) begin
			count_n = count_q + 3'd1;
		end else if (rx_byte == CH_DOLLAR) begin
			count_n = 3'd1;
		end else begin
			count_n = 3'd0;
		end
		hit = (count_n == HDR_LEN);
	end

	// The count returns to zero after a full match.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 3'd0;
		end else if (step) begin
			count_q <= hit ? 3'd0 : count_n;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/nrpe_parser.sv =====
`default_nettype none

module nrpe_parser
	import nrpe_pkg::*;
#(
	parameter int FIELD_CHARS = NRPE_FIELD_CHARS,
	parameter int FRACTION_DIGITS = NRPE_FRACTION_DIGITS
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       step,
	input  wire logic       hit,
	input  wire logic [7:0] rx_byte,
	output result_t         res
);

	localparam int FC_W = $clog2(FIELD_CHARS + 1);
	localparam int FD_W = $clog2(FRACTION_DIGITS + 1);
	localparam int MAC_W = VALUE_W + 4;
	localparam int FIN_W = VALUE_W + POW10_W;

	phase_t             phase_q, phase_d;
	logic [1:0]         skip_q, skip_d, skip_dec;
	logic [FC_W-1:0]    fcnt_q, fcnt_d;
	logic               frac_q, frac_d;
	logic               ended_q, ended_d;
	logic [FD_W-1:0]    fd_q, fd_d;
	logic [VALUE_W-1:0] lat_q, lat_d;
	logic [VALUE_W-1:0] lon_q, lon_d;

	logic               is_lf, is_comma, is_digit, is_dot, field_full;
	logic [VALUE_W-1:0] cur_acc, fed_acc, mac_val, fin_val;
	logic [MAC_W-1:0]   mac_prod;
	logic [FIN_W-1:0]   fin_prod;
	logic [FD_W-1:0]    pad_k;

	assign is_lf      = (rx_byte == CH_LF);
	assign is_comma   = (rx_byte == CH_COMMA);
	assign is_dot     = (rx_byte == CH_DOT);
	assign is_digit   = (rx_byte >= CH_0) && (rx_byte <= CH_9);
	assign field_full = (fcnt_q >= FC_W'(FIELD_CHARS));
	assign skip_dec   = (skip_q != 2'd0) ? skip_q - 2'd1 : skip_q;
	assign cur_acc    = (phase_q == PH_LON) ? lon_q : lat_q;

	// Saturating multiply by ten and add the new digit.
	always_comb begin
		logic [7:0] digit;
		digit    = rx_byte - CH_0;
		mac_prod = MAC_W'(cur_acc) * MAC_W'(10) + MAC_W'(digit[3:0]);
		mac_val  = (mac_prod > MAC_W'(SAT_MAX)) ? SAT_MAX : mac_prod[VALUE_W-1:0];
	end

	// Pad a short fraction: scale by the missing power of ten, saturating.
	always_comb begin
		pad_k    = FD_W'(FRACTION_DIGITS) - fd_q;
		fin_prod = FIN_W'(cur_acc) * FIN_W'(pow10(3'(pad_k)));
		fin_val  = (fin_prod > FIN_W'(SAT_MAX)) ? SAT_MAX : fin_prod[VALUE_W-1:0];
	end

	// Next parse phase.
	always_comb begin
		phase_d = phase_q;
		if (hit) begin
			phase_d = PH_WAIT_A;
		end else begin
			unique case (phase_q)
				PH_WAIT_LF: begin
					if (is_lf) phase_d = PH_SEARCH;
				end
				PH_WAIT_A: begin
					if (is_lf) phase_d = PH_SEARCH;
					else if (rx_byte == CH_A) phase_d = PH_SKIP_LAT;
				end
				PH_SKIP_LAT, PH_SKIP_LON: begin
					if (is_lf) begin
						phase_d = PH_SEARCH;
					end else if (skip_dec == 2'd0) begin
						phase_d = (phase_q == PH_SKIP_LAT) ? PH_LAT : PH_LON;
					end
				end
				PH_LAT, PH_LON: begin
					if (is_lf) begin
						phase_d = PH_SEARCH;
					end else if (is_comma) begin
						phase_d = (phase_q == PH_LAT) ? PH_SKIP_LON : PH_WAIT_LF;
					end else if (field_full) begin
						phase_d = PH_SEARCH;
					end
				end
				default: phase_d = PH_SEARCH;
			endcase
		end
	end

	// Number conversion of one field character.
	always_comb begin
		fed_acc = cur_acc;
		frac_d  = frac_q;
		ended_d = ended_q;
		fd_d    = fd_q;
		if (!ended_q) begin
			if (is_digit) begin
				if (!frac_q) begin
					fed_acc = mac_val;
				end else if (fd_q < FD_W'(FRACTION_DIGITS)) begin
					fed_acc = mac_val;
					fd_d    = fd_q + FD_W'(1);
				end
			end else if (is_dot && !frac_q) begin
				frac_d = 1'b1;
			end else begin
				ended_d = 1'b1;
			end
		end
	end

	// Counters, field flags and accumulators.
	logic [FC_W-1:0]    fcnt_n;
	logic               frac_n, ended_n;
	logic [FD_W-1:0]    fd_n;
	always_comb begin
		skip_d  = skip_q;
		fcnt_n  = fcnt_q;
		frac_n  = frac_q;
		ended_n = ended_q;
		fd_n    = fd_q;
		lat_d   = lat_q;
		lon_d   = lon_q;
		if (hit) begin
			skip_d  = 2'd0;
			fcnt_n  = '0;
			frac_n  = 1'b0;
			ended_n = 1'b0;
			fd_n    = '0;
			lat_d   = '0;
			lon_d   = '0;
		end else if (!is_lf) begin
			unique case (phase_q)
				PH_WAIT_A: begin
					if (rx_byte == CH_A) skip_d = 2'd1;
				end
				PH_SKIP_LAT, PH_SKIP_LON: begin
					skip_d = skip_dec;
					if (skip_dec == 2'd0) begin
						fcnt_n  = '0;
						frac_n  = 1'b0;
						ended_n = 1'b0;
						fd_n    = '0;
					end
				end
				PH_LAT, PH_LON: begin
					if (is_comma) begin
						if (phase_q == PH_LAT) begin
							lat_d  = fin_val;
							skip_d = 2'd2;
						end else begin
							lon_d = fin_val;
						end
					end else if (!field_full) begin
						fcnt_n  = fcnt_q + FC_W'(1);
						frac_n  = frac_d;
						ended_n = ended_d;
						fd_n    = fd_d;
						if (phase_q == PH_LAT) lat_d = fed_acc;
						else lon_d = fed_acc;
					end
				end
				default: ;
			endcase
		end
		fcnt_d = fcnt_n;
	end

	// A sentence yields its position on the line feed when both values are set.
	always_comb begin
		res.emit = !hit && (phase_q == PH_WAIT_LF) && is_lf &&
			(lat_q != '0) && (lon_q != '0);
		res.lat  = lat_q;
		res.lon  = lon_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SEARCH;
			skip_q  <= 2'd0;
			fcnt_q  <= '0;
			frac_q  <= 1'b0;
			ended_q <= 1'b0;
			fd_q    <= '0;
			lat_q   <= '0;
			lon_q   <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			skip_q  <= skip_d;
			fcnt_q  <= fcnt_d;
			frac_q  <= frac_n;
			ended_q <= ended_n;
			fd_q    <= fd_n;
			lat_q   <= lat_d;
			lon_q   <= lon_d;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/nmea_rmc_position_extractor_unit.sv =====
`default_nettype none

// Extracts latitude and longitude from "$GPRMC" sentences in a byte stream.
// One byte is taken per cycle, back to back: a byte is held in an input
// register, parsed by a combinational step (header matcher, phase logic and a
// saturating decimal accumulator), and a result lands in an output register
// once the line feed has been parsed. Each value is the field text times
// 10^FRACTION_DIGITS; a result appears only when both are nonzero.
// The input keeps flowing while a result waits, and stalls only when a second
// result is ready before the first has been taken.
module nmea_rmc_position_extractor_unit
	import nrpe_pkg::*;
#(
	parameter int FIELD_CHARS = NRPE_FIELD_CHARS,
	parameter int FRACTION_DIGITS = NRPE_FRACTION_DIGITS
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [7:0]         rx_byte,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [VALUE_W-1:0]      latitude_scaled,
	output logic [VALUE_W-1:0]      longitude_scaled
);

	logic               valid_s1;
	logic [7:0]         byte_s1;
	logic               out_valid_q;
	logic [VALUE_W-1:0] lat_q, lon_q;
	logic               hit, advance, step;
	result_t            res;

	// A byte leaves the input register unless its result finds the output full.
	assign advance  = !res.emit || !out_valid_q || out_ready;
	assign step     = valid_s1 && advance;
	assign in_ready = !valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) byte_s1 <= rx_byte;
	end

	nrpe_hdr_match u_hdr (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.rx_byte (byte_s1),
		.hit     (hit)
	);

	nrpe_parser #(
		.FIELD_CHARS     (FIELD_CHARS),
		.FRACTION_DIGITS (FRACTION_DIGITS)
	) u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.hit     (hit),
		.rx_byte (byte_s1),
		.res     (res)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && res.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res.emit) begin
			lat_q <= res.lat;
			lon_q <= res.lon;
		end
	end

	assign out_valid        = out_valid_q;
	assign latitude_scaled  = lat_q;
	assign longitude_scaled = lon_q;

	// A result is only produced by a line feed.
	a_emit_on_lf: assert property (@(posedge clk) disable iff (!arst_n)
		(step && res.emit) |-> (byte_s1 == CH_LF))
		else $error("result produced by a byte other than line feed");

	// A delivered position never has a zero coordinate.
	a_out_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (lat_q != '0) && (lon_q != '0))
		else $error("result transaction with a zero coordinate");

	// Saturation keeps both values within nine decimal digits.
	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (lat_q <= SAT_MAX) && (lon_q <= SAT_MAX))
		else $error("result value above saturation limit");

	// A byte whose result cannot be stored stays in the input register.
	a_hold_on_full: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && res.emit && out_valid_q && !out_ready) |=>
			(valid_s1 && $stable(byte_s1)))
		else $error("input byte lost while output register full");

endmodule

`default_nettype wire
